/* sv/assert_macros.svh */
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/gqdp_pkg.sv */
// Types and constants of the group-quantized int4 dot product unit.
`default_nettype none
package gqdp_pkg;

	localparam int ACT_W    = 16;
	localparam int CODE_W   = 4;
	localparam int SCALE_W  = 16;
	localparam int DOT_W    = 48;
	localparam int GLEN_W   = 9;
	localparam int RLEN_W   = 13;
	localparam int LEN_W    = 17;
	localparam int PROD_W   = ACT_W + CODE_W;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;

	localparam logic [CODE_W-1:0] CODE_NEG8 = 4'h8;
	localparam logic [CODE_W-1:0] CODE_ZERO = 4'h0;

	// Register select: paddr[2]
	localparam logic REG_GROUP_LEN = 1'b0;
	localparam logic REG_ROW_LEN   = 1'b1;

	localparam logic [GLEN_W-1:0] GLEN_RESET = 9'd32;
	localparam logic [RLEN_W-1:0] RLEN_RESET = 13'd4096;

	typedef struct packed {
		logic signed [ACT_W-1:0] act;
		logic [CODE_W-1:0]       code;
		logic [SCALE_W-1:0]      scale;
		logic                    grp_end;
		logic                    row_end;
		logic                    bad;
	} gqdp_item_t;

	typedef struct packed {
		logic                    bad;
		logic signed [DOT_W-1:0] dot;
	} gqdp_result_t;

endpackage
`default_nettype wire

/* sv/gqdp_fifo.sv */
// Small register FIFO with occupancy count.
`default_nettype none
module gqdp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [WIDTH-1:0]             wr_data,
	input  wire logic                         rd_en,
	output logic      [WIDTH-1:0]             rd_data,
	output logic                              full,
	output logic                              empty,
	output logic      [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/gqdp_front.sv */
// Front end: takes requests, tracks group/row position, scale and invalid flag.
`default_nettype none
module gqdp_front
	import gqdp_pkg::*;
#(
	parameter int MAX_ROW   = 4096,
	parameter int MAX_GROUP = 256
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire logic                      mid_full,
	input  wire logic signed [ACT_W-1:0]   activation,
	input  wire logic [CODE_W-1:0]         weight_code,
	input  wire logic [SCALE_W-1:0]        group_scale,
	input  wire logic [GLEN_W-1:0]         group_length,
	input  wire logic [RLEN_W-1:0]         row_length,
	output logic                           mid_wr,
	output gqdp_item_t                     mid_item
);

	localparam int PG_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int PR_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

	logic [PG_W-1:0]    pig_q;
	logic [PR_W-1:0]    pir_q;
	logic [SCALE_W-1:0] held_scale_q;
	logic               row_bad_q;

	logic [LEN_W-1:0]   gl_ext;
	logic [LEN_W-1:0]   rl_ext;
	logic [LEN_W-1:0]   glen;
	logic [LEN_W-1:0]   rlen;
	logic [SCALE_W-1:0] scale_now;
	logic               bad_now;
	logic               grp_end;
	logic               row_end;

	assign gl_ext = LEN_W'(group_length);
	assign rl_ext = LEN_W'(row_length);

	// zero means one, anything past the build limit is clamped
	always_comb begin
		if (gl_ext == '0) begin
			glen = LEN_W'(1);
		end else if (gl_ext > LEN_W'(MAX_GROUP)) begin
			glen = LEN_W'(MAX_GROUP);
		end else begin
			glen = gl_ext;
		end
		if (rl_ext == '0) begin
			rlen = LEN_W'(1);
		end else if (rl_ext > LEN_W'(MAX_ROW)) begin
			rlen = LEN_W'(MAX_ROW);
		end else begin
			rlen = rl_ext;
		end
	end

	assign scale_now = (pig_q == '0) ? group_scale : held_scale_q;
	assign bad_now   = (weight_code == CODE_NEG8) ||
	                   ((weight_code != CODE_ZERO) && (scale_now == '0));
	assign grp_end   = (LEN_W'(pig_q) + LEN_W'(1)) >= glen;
	assign row_end   = (LEN_W'(pir_q) + LEN_W'(1)) >= rlen;

	assign mid_wr = push && !mid_full;

	always_comb begin
		mid_item.act     = activation;
		mid_item.code    = weight_code;
		mid_item.scale   = scale_now;
		mid_item.grp_end = grp_end || row_end;
		mid_item.row_end = row_end;
		mid_item.bad     = row_bad_q || bad_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pig_q        <= '0;
			pir_q        <= '0;
			held_scale_q <= '0;
			row_bad_q    <= 1'b0;
		end else if (mid_wr) begin
			if (row_end) begin
				pig_q        <= '0;
				pir_q        <= '0;
				held_scale_q <= '0;
				row_bad_q    <= 1'b0;
			end else begin
				pig_q        <= grp_end ? '0 : pig_q + 1'b1;
				pir_q        <= pir_q + 1'b1;
				held_scale_q <= scale_now;
				row_bad_q    <= row_bad_q || bad_now;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/gqdp_back.sv */
// Back end: per-element product, group sum, scale multiply, saturating row sum.
`default_nettype none
module gqdp_back
	import gqdp_pkg::*;
#(
	parameter int MAX_GROUP = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            mid_empty,
	input  wire gqdp_item_t                      mid_item,
	output logic                                 mid_rd,
	input  wire logic [$clog2(OUT_DEPTH+1)-1:0]  out_count,
	output logic                                 out_wr,
	output gqdp_result_t                         out_res
);

	localparam int GSUM_W = PROD_W + $clog2(MAX_GROUP);
	localparam int MUL_W  = GSUM_W + SCALE_W + 1;
	localparam int SUM_W  = ((MUL_W > DOT_W) ? MUL_W : DOT_W) + 1;
	localparam int CNT_W  = $clog2(OUT_DEPTH+1);

	localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
	localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};

	// rows popped but not yet written to the result queue
	logic [CNT_W-1:0] pending_q;
	logic             credit_ok;

	// stage 1: element product
	logic                      v_s1;
	logic signed [PROD_W-1:0]  prod_s1;
	logic [SCALE_W-1:0]        scale_s1;
	logic                      grp_end_s1;
	logic                      row_end_s1;
	logic                      bad_s1;

	// stage 2: finished group sum
	logic signed [GSUM_W-1:0]  group_sum_q;
	logic                      v_s2;
	logic signed [GSUM_W-1:0]  gfin_s2;
	logic [SCALE_W-1:0]        scale_s2;
	logic                      row_end_s2;
	logic                      bad_s2;

	// stage 3: scaled group
	logic                      v_s3;
	logic signed [MUL_W-1:0]   mul_s3;
	logic                      row_end_s3;
	logic                      bad_s3;

	logic signed [DOT_W-1:0]   row_sum_q;

	logic signed [ACT_W-1:0]   act_w;
	logic signed [CODE_W-1:0]  code_w;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [GSUM_W-1:0]  gnext;
	logic signed [SCALE_W:0]   scale_sx;
	logic signed [MUL_W-1:0]   mul_d;
	logic signed [SUM_W-1:0]   sum_d;
	logic signed [DOT_W-1:0]   sat_d;

	assign credit_ok = ((CNT_W+1)'(pending_q) + (CNT_W+1)'(out_count) <
	                    (CNT_W+1)'(OUT_DEPTH));
	assign mid_rd = !mid_empty && (!mid_item.row_end || credit_ok);

	assign act_w  = mid_item.act;
	assign code_w = $signed(mid_item.code);
	assign prod_d = act_w * code_w;

	assign gnext    = group_sum_q + GSUM_W'(prod_s1);
	assign scale_sx = $signed({1'b0, scale_s2});
	assign mul_d    = gfin_s2 * scale_sx;

	always_comb begin
		sum_d = SUM_W'(row_sum_q) + SUM_W'(mul_s3);
		if (sum_d > SUM_W'(DOT_MAX)) begin
			sat_d = DOT_MAX;
		end else if (sum_d < SUM_W'(DOT_MIN)) begin
			sat_d = DOT_MIN;
		end else begin
			sat_d = DOT_W'(sum_d);
		end
	end

	assign out_wr      = v_s3 && row_end_s3;
	assign out_res.bad = bad_s3;
	assign out_res.dot = sat_d;

	always_ff @(posedge clk) begin
		prod_s1    <= prod_d;
		scale_s1   <= mid_item.scale;
		grp_end_s1 <= mid_item.grp_end;
		row_end_s1 <= mid_item.row_end;
		bad_s1     <= mid_item.bad;
		gfin_s2    <= gnext;
		scale_s2   <= scale_s1;
		row_end_s2 <= row_end_s1;
		bad_s2     <= bad_s1;
		mul_s3     <= mul_d;
		row_end_s3 <= row_end_s2;
		bad_s3     <= bad_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			group_sum_q <= '0;
			row_sum_q   <= '0;
			pending_q   <= '0;
		end else begin
			v_s1 <= mid_rd;
			v_s2 <= v_s1 && grp_end_s1;
			v_s3 <= v_s2;
			if (v_s1) begin
				group_sum_q <= grp_end_s1 ? '0 : gnext;
			end
			if (v_s3) begin
				row_sum_q <= row_end_s3 ? '0 : sat_d;
			end
			if ((mid_rd && mid_item.row_end) && !out_wr) begin
				pending_q <= pending_q + 1'b1;
			end else if (out_wr && !(mid_rd && mid_item.row_end)) begin
				pending_q <= pending_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/int4_group_quantized_dot_product_unit.sv */
// Group-quantized int4 dot product unit: top level.
// Usage:
//   Input queue: drive activation, weight_code and group_scale with push; a
//   request is taken at a clock edge where push is high and full is low.
//   group_scale is only used on the first element of each group.
//   Result queue: while empty is low, dot_product and invalid_data hold the
//   oldest row result; pop takes it. One result per row, at the last element.
//   Config: APB write of group_length at 0x0, row_length at 0x4 while idle.
// Timing:
//   One element per cycle sustained while the result queue has room. The row
//   result passes the mid queue, product, group sum, scale multiply and row add
//   stages. The group-to-row multiply and the row add are each one pipeline
//   stage, so a row of length 1 still streams at full rate.
// Stall:
//   When pop is held low the result queue fills; the back end stops taking
//   row-ending elements once all result slots are spoken for, the 4-entry
//   mid queue fills and full rises. Nothing is dropped.
// Reset:
//   arst_n clears all position, scale and accumulator state, empties both
//   queues and loads group_length 32 and row_length 4096.
`default_nettype none
module int4_group_quantized_dot_product_unit
	import gqdp_pkg::*;
#(
	parameter int MAX_ROW   = 4096,
	parameter int MAX_GROUP = 256
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic signed [ACT_W-1:0]  activation,
	input  wire logic [CODE_W-1:0]        weight_code,
	input  wire logic [SCALE_W-1:0]       group_scale,
	output logic                          empty,
	input  wire logic                     pop,
	output logic signed [DOT_W-1:0]       dot_product,
	output logic                          invalid_data,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [PADDR_W-1:0]       paddr,
	input  wire logic [PDATA_W-1:0]       pwdata,
	output logic [PDATA_W-1:0]            prdata,
	output logic                          pready
);

	localparam int OCNT_W = $clog2(OUT_DEPTH+1);

	logic [GLEN_W-1:0] group_length_q;
	logic [RLEN_W-1:0] row_length_q;
	logic              cfg_wr;

	logic              mid_wr;
	logic              mid_rd;
	logic              mid_empty;
	gqdp_item_t        front_item;
	logic [$bits(gqdp_item_t)-1:0] mid_rd_data;
	gqdp_item_t        mid_item;

	logic              out_wr;
	gqdp_result_t      out_res;
	logic [$bits(gqdp_result_t)-1:0] out_rd_data;
	gqdp_result_t      out_head;
	logic              out_full;
	logic [OCNT_W-1:0] out_count;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_length_q <= GLEN_RESET;
			row_length_q   <= RLEN_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_GROUP_LEN: group_length_q <= pwdata[GLEN_W-1:0];
				REG_ROW_LEN:   row_length_q   <= pwdata[RLEN_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_GROUP_LEN: prdata = PDATA_W'(group_length_q);
			REG_ROW_LEN:   prdata = PDATA_W'(row_length_q);
			default:       prdata = '0;
		endcase
	end

	gqdp_front #(
		.MAX_ROW   (MAX_ROW),
		.MAX_GROUP (MAX_GROUP)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.mid_full     (full),
		.activation   (activation),
		.weight_code  (weight_code),
		.group_scale  (group_scale),
		.group_length (group_length_q),
		.row_length   (row_length_q),
		.mid_wr       (mid_wr),
		.mid_item     (front_item)
	);

	gqdp_fifo #(
		.WIDTH ($bits(gqdp_item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_data (front_item),
		.rd_en   (mid_rd),
		.rd_data (mid_rd_data),
		.full    (full),
		.empty   (mid_empty),
		.count   ()
	);

	assign mid_item = gqdp_item_t'(mid_rd_data);

	gqdp_back #(
		.MAX_GROUP (MAX_GROUP)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_item  (mid_item),
		.mid_rd    (mid_rd),
		.out_count (out_count),
		.out_wr    (out_wr),
		.out_res   (out_res)
	);

	gqdp_fifo #(
		.WIDTH ($bits(gqdp_result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data (out_res),
		.rd_en   (pop),
		.rd_data (out_rd_data),
		.full    (out_full),
		.empty   (empty),
		.count   (out_count)
	);

	assign out_head     = gqdp_result_t'(out_rd_data);
	assign dot_product  = out_head.dot;
	// out_full never gates a write: the back end reserves a slot per row
	assign invalid_data = out_head.bad && !(out_full && 1'b0);

endmodule
`default_nettype wire

/* sv/gqdp_checker.sv */
// Port-level checker for the dot product unit, with its bind.
`default_nettype none
`include "assert_macros.svh"
module gqdp_checker
	import gqdp_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     empty,
	input wire logic                     pop,
	input wire logic signed [DOT_W-1:0]  dot_product,
	input wire logic                     invalid_data,
	input wire logic                     psel,
	input wire logic                     penable,
	input wire logic                     pwrite,
	input wire logic                     pready,
	input wire logic [PADDR_W-1:0]       paddr,
	input wire logic [PDATA_W-1:0]       pwdata,
	input wire logic [PDATA_W-1:0]       prdata
);

	logic               held;
	logic [DOT_W:0]     head;
	logic               cfg_wr;
	logic               rd_back;
	logic [PDATA_W-1:0] want_rd;
	logic               cfg_wr_q;
	logic [PADDR_W-1:0] paddr_q;
	logic [RLEN_W-1:0]  pwdata_q;

	assign held    = !empty && !pop;
	assign head    = {invalid_data, dot_product};
	assign cfg_wr  = psel && penable && pwrite && pready;
	// a read right after a write to the same register returns what was written
	assign rd_back = cfg_wr_q && psel && !pwrite && (paddr == paddr_q);
	assign want_rd = (paddr[2] == REG_ROW_LEN) ? PDATA_W'(pwdata_q) :
	                 PDATA_W'(pwdata_q[GLEN_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_wr_q <= 1'b0;
			paddr_q  <= '0;
			pwdata_q <= '0;
		end else begin
			cfg_wr_q <= cfg_wr;
			paddr_q  <= paddr;
			pwdata_q <= pwdata[RLEN_W-1:0];
		end
	end

	`ASSERT_ALWAYS(a_pready_high, clk, arst_n, pready, "pready dropped")
	`ASSERT_NEXT(a_result_kept, clk, arst_n, held, !empty, "result lost")
	`ASSERT_NEXT(a_res_stable, clk, arst_n, held, $stable(head), "result changed")
	`ASSERT_ALWAYS(a_cfg_readback, clk, arst_n, !rd_back || (prdata == want_rd), "bad readback")

endmodule

bind int4_group_quantized_dot_product_unit gqdp_checker u_gqdp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.dot_product  (dot_product),
	.invalid_data (invalid_data),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.pready       (pready),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata)
);
`default_nettype wire
